### design/grcw_pkg.sv
package grcw_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_WALK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam int REG_WIDTH  = 0;
    localparam int REG_HEIGHT = 1;

    localparam int VW = 13;

    localparam logic [7:0] F_FROM_SRC  = 8'h01;
    localparam logic [7:0] F_TO_SRC    = 8'h02;
    localparam logic [7:0] F_FROM_SINK = 8'h04;
    localparam logic [7:0] F_TO_SINK   = 8'h08;
    localparam logic [7:0] F_RIGHT     = 8'h10;
    localparam logic [7:0] F_DOWN      = 8'h20;
    localparam logic [7:0] F_LEFT      = 8'h40;
    localparam logic [7:0] F_UP        = 8'h80;

    typedef struct packed {
        logic       start;
        logic [1:0] cmd;
        logic [7:0] flags;
        logic [VW-1:0] position;
    } grcw_req_t;

    typedef struct packed {
        logic          done;
        logic [VW-1:0] cut_vertex;
        logic [VW-1:0] cut_count;
        logic          entry_valid;
    } grcw_rsp_t;

endpackage

### design/grcw_cfg.sv
module grcw_cfg import grcw_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [10:0] eff_w,
    output logic [10:0] eff_h
);
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
        end else if (wr_en) begin
            if (paddr[2] == 1'(REG_WIDTH)) width_reg <= pwdata[6:0];
            else height_reg <= pwdata[6:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'(REG_WIDTH)) prdata[6:0] = width_reg;
        else prdata[6:0] = height_reg;
    end

    always_comb begin
        if (width_reg == 7'd0) eff_w = 11'd1;
        else if (32'(width_reg) > MAX_WIDTH) eff_w = 11'(MAX_WIDTH);
        else eff_w = 11'(width_reg);
        if (height_reg == 7'd0) eff_h = 11'd1;
        else if (32'(height_reg) > MAX_HEIGHT) eff_h = 11'(MAX_HEIGHT);
        else eff_h = 11'(height_reg);
    end
endmodule

### design/grcw_core.sv
module grcw_core import grcw_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [10:0] eff_w,
    input  logic [10:0] eff_h,
    input  grcw_req_t   req,
    output grcw_rsp_t   rsp
);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int VERTS = CELLS + 2;
    localparam int CA = $clog2(CELLS);
    localparam int VA = $clog2(VERTS);
    localparam int KW = $clog2(CELLS + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = VW + KW + RW + CW;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_PUSH   = 4'd2;
    localparam logic [3:0] ST_TOP    = 4'd3;
    localparam logic [3:0] ST_FETCH  = 4'd4;
    localparam logic [3:0] ST_STEP   = 4'd5;
    localparam logic [3:0] ST_WAIT   = 4'd6;
    localparam logic [3:0] ST_VIS    = 4'd7;
    localparam logic [3:0] ST_CHECK  = 4'd8;
    localparam logic [3:0] ST_READ   = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [7:0]    flag_mem [CELLS];
    logic          vis_mem  [VERTS];
    logic [SW-1:0] stk_mem  [VERTS];
    logic [VW-1:0] cut_mem  [VERTS];

    logic [3:0]    state_reg;
    logic [CA-1:0] lp_reg;
    logic [VW-1:0] len_reg;
    logic [VA:0]   sp_reg;
    logic [VA-1:0] clr_reg;
    logic [VW-1:0] n_reg;
    logic [10:0]   w_reg;
    logic [10:0]   h_reg;
    logic [VW-1:0] cur_v_reg;
    logic [KW-1:0] cur_c_reg;
    logic [RW-1:0] cur_row_reg;
    logic [CW-1:0] cur_col_reg;
    logic [VW-1:0] nb_reg;
    logic [RW-1:0] nb_row_reg;
    logic [CW-1:0] nb_col_reg;
    logic [VW-1:0] rd_v_reg;
    logic          rd_ok_reg;
    logic [7:0]    flag_q;
    logic          vis_q;
    logic [SW-1:0] top_q;
    logic [VW-1:0] cut_q;

    logic [VW-1:0] top_v;
    logic [KW-1:0] top_c;
    logic [RW-1:0] top_row;
    logic [CW-1:0] top_col;
    logic [CA-1:0] f_addr;
    logic [VW-1:0] n_now;
    logic [VW-1:0] sink;
    logic          is_end;
    logic          nb_end;
    logic          exhausted;
    logic          hit;
    logic [VW-1:0] hit_v;
    logic [RW-1:0] hit_row;
    logic [CW-1:0] hit_col;
    logic [KW-1:0] c_next;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_next;
    logic [RW-1:0] end_row;
    logic [CW-1:0] end_col;
    logic [CA:0]   lp_inc;
    logic [7:0]    bit_mask;
    logic          stk_we;
    logic [VA-1:0] stk_wa;
    logic [SW-1:0] stk_wd;

    assign n_now = VW'(eff_w) * VW'(eff_h);
    assign sink  = n_reg + VW'(1);
    assign is_end = (cur_v_reg == '0) || (cur_v_reg == sink);
    assign nb_end = (nb_reg == '0) || (nb_reg == sink);
    assign exhausted = is_end ? (cur_c_reg == '0) : (cur_c_reg >= KW'(6));
    assign lp_inc = {1'b0, lp_reg} + 1'b1;
    assign bit_mask = (cur_v_reg == '0) ? F_FROM_SRC : F_FROM_SINK;
    assign end_row = RW'(h_reg - 11'd1);
    assign end_col = CW'(w_reg - 11'd1);
    assign {top_v, top_c, top_row, top_col} = top_q;

    always_comb begin
        if (state_reg == ST_FETCH) begin
            if (top_v == '0 || top_v == sink) f_addr = CA'(top_c - KW'(1));
            else f_addr = CA'(top_v - VW'(1));
        end else if (is_end) begin
            f_addr = CA'(cur_c_reg - KW'(1));
        end else begin
            f_addr = CA'(cur_v_reg - VW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        flag_q <= flag_mem[f_addr];
        vis_q  <= vis_mem[VA'(nb_reg)];
        top_q  <= stk_mem[VA'(sp_reg - 1'b1)];
        cut_q  <= cut_mem[VA'(req.position)];
    end

    always_comb begin
        hit = 1'b0;
        hit_v = '0;
        hit_row = end_row;
        hit_col = end_col;
        c_next = cur_c_reg;
        row_next = cur_row_reg;
        col_next = cur_col_reg;
        if (is_end) begin
            c_next = cur_c_reg - KW'(1);
            if (cur_col_reg == '0) begin
                col_next = end_col;
                row_next = cur_row_reg - RW'(1);
            end else begin
                col_next = cur_col_reg - CW'(1);
            end
            hit = (flag_q & bit_mask) != 8'd0;
            hit_v = VW'(cur_c_reg);
            hit_row = cur_row_reg;
            hit_col = cur_col_reg;
        end else begin
            c_next = cur_c_reg + KW'(1);
            case (cur_c_reg[2:0])
                3'd0: begin
                    hit = (flag_q & F_UP) != 8'd0 && cur_row_reg != '0;
                    hit_v = cur_v_reg - VW'(w_reg);
                    hit_row = cur_row_reg - RW'(1);
                    hit_col = cur_col_reg;
                end
                3'd1: begin
                    hit = (flag_q & F_LEFT) != 8'd0 && cur_col_reg != '0;
                    hit_v = cur_v_reg - VW'(1);
                    hit_row = cur_row_reg;
                    hit_col = cur_col_reg - CW'(1);
                end
                3'd2: begin
                    hit = (flag_q & F_DOWN) != 8'd0 && 11'(cur_row_reg) + 11'd1 < h_reg;
                    hit_v = cur_v_reg + VW'(w_reg);
                    hit_row = cur_row_reg + RW'(1);
                    hit_col = cur_col_reg;
                end
                3'd3: begin
                    hit = (flag_q & F_RIGHT) != 8'd0 && 11'(cur_col_reg) + 11'd1 < w_reg;
                    hit_v = cur_v_reg + VW'(1);
                    hit_row = cur_row_reg;
                    hit_col = cur_col_reg + CW'(1);
                end
                3'd4: begin
                    hit = (flag_q & F_TO_SINK) != 8'd0;
                    hit_v = sink;
                end
                3'd5: begin
                    hit = (flag_q & F_TO_SRC) != 8'd0;
                    hit_v = '0;
                end
                default: begin
                    hit = 1'b0;
                    hit_v = '0;
                end
            endcase
        end
    end

    always_comb begin
        stk_we = 1'b0;
        stk_wa = VA'(sp_reg - 1'b1);
        stk_wd = {cur_v_reg, cur_c_reg, cur_row_reg, cur_col_reg};
        if (state_reg == ST_PUSH) begin
            stk_we = 1'b1;
            stk_wa = VA'(sp_reg);
            stk_wd = {nb_reg, nb_end ? KW'(n_reg) : KW'(0), nb_row_reg, nb_col_reg};
        end else if (state_reg == ST_CHECK && !vis_q) begin
            stk_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && req.start && req.cmd == CMD_LOAD)
            flag_mem[(32'(lp_reg) < 32'(n_now)) ? lp_reg : CA'(0)] <= req.flags;
        if (state_reg == ST_CLEAR) vis_mem[clr_reg] <= 1'b0;
        else if (state_reg == ST_PUSH) vis_mem[VA'(nb_reg)] <= 1'b1;
        if (state_reg == ST_PUSH) cut_mem[VA'(len_reg)] <= nb_reg;
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lp_reg <= '0;
            len_reg <= '0;
            sp_reg <= '0;
            clr_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (req.start) begin
                    case (req.cmd)
                        CMD_LOAD: begin
                            if (32'(lp_reg) >= 32'(n_now))
                                lp_reg <= (n_now == VW'(1)) ? '0 : CA'(1);
                            else if (32'(lp_inc) >= 32'(n_now)) lp_reg <= '0;
                            else lp_reg <= CA'(lp_inc);
                            state_reg <= ST_DONE;
                        end
                        CMD_WALK: begin
                            n_reg <= n_now;
                            w_reg <= eff_w;
                            h_reg <= eff_h;
                            clr_reg <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        CMD_READ: state_reg <= ST_READ;
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == 32'(n_reg) + 1) begin
                        len_reg <= '0;
                        sp_reg <= '0;
                        nb_reg <= n_reg + VW'(1);
                        nb_row_reg <= end_row;
                        nb_col_reg <= end_col;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    len_reg <= len_reg + VW'(1);
                    sp_reg <= sp_reg + 1'b1;
                    state_reg <= ST_TOP;
                end
                ST_TOP: begin
                    if (sp_reg == '0) state_reg <= ST_DONE;
                    else state_reg <= ST_FETCH;
                end
                ST_FETCH: begin
                    cur_v_reg <= top_v;
                    cur_c_reg <= top_c;
                    cur_row_reg <= top_row;
                    cur_col_reg <= top_col;
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    if (exhausted) begin
                        sp_reg <= sp_reg - 1'b1;
                        state_reg <= ST_TOP;
                    end else begin
                        cur_c_reg <= c_next;
                        cur_row_reg <= row_next;
                        cur_col_reg <= col_next;
                        if (hit) begin
                            nb_reg <= hit_v;
                            nb_row_reg <= hit_row;
                            nb_col_reg <= hit_col;
                            state_reg <= ST_VIS;
                        end else if (is_end) begin
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: state_reg <= ST_STEP;
                ST_VIS: state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= vis_q ? ST_STEP : ST_PUSH;
                ST_READ: state_reg <= ST_DONE;
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE)
            rd_ok_reg <= req.start && req.cmd == CMD_READ && req.position < len_reg;
        if (state_reg == ST_READ) rd_v_reg <= cut_q;
    end

    assign rsp.done = state_reg == ST_DONE;
    assign rsp.cut_vertex = rd_ok_reg ? rd_v_reg : '0;
    assign rsp.cut_count = len_reg;
    assign rsp.entry_valid = rd_ok_reg;
endmodule

### design/grid_residual_cut_walk.sv
// Load: IDLE, DONE. Read: IDLE, READ, DONE. No new request till the result register is taken.
// Walk: clear the W*H+2 visited marks; STEP, VIS, CHECK per neighbour found; PUSH, TOP,
//   FETCH per new vertex; STEP per cell slot tried, or STEP, WAIT per cell scanned from an
//   end vertex; STEP, TOP, FETCH per pop; TOP, DONE to finish.
// aresetn synchronous, active low: registers to 64, load pointer and cut length to 0.
module grid_residual_cut_walk import grcw_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cell_flags[7:0], position[20:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cut_vertex[12:0], cut_count[25:13]
    output logic        m_tuser    // entry_valid
);
    logic [10:0] eff_w;
    logic [10:0] eff_h;
    logic        busy_reg;
    logic        out_v_reg;
    logic [26:0] out_reg;
    grcw_req_t   req;
    grcw_rsp_t   rsp;

    grcw_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .eff_w, .eff_h
    );

    assign s_tready = !busy_reg && !out_v_reg;
    assign req.start = s_tvalid && s_tready;
    assign req.cmd = s_tuser[1:0];
    assign req.flags = s_tdata[7:0];
    assign req.position = s_tdata[20:8];

    grcw_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_core (
        .aclk, .aresetn, .eff_w, .eff_h, .req, .rsp
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (req.start) busy_reg <= 1'b1;
            if (rsp.done) begin
                busy_reg <= 1'b0;
                out_v_reg <= 1'b1;
                out_reg <= {rsp.entry_valid, rsp.cut_count, rsp.cut_vertex};
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {6'd0, out_reg[25:0]};
    assign m_tuser = out_reg[26];

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_valid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[12:0] == 13'd0) else $error("vertex not zero");
`endif
endmodule

### tb/tb_grid_residual_cut_walk.sv
module tb_grid_residual_cut_walk;
    import grcw_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int VERT_CAP = MAX_WIDTH_DEF * MAX_HEIGHT_DEF + 2;

    typedef struct {
        logic [12:0] vertex;
        logic [12:0] count;
        logic        valid;
    } cut_answer_t;

    class cut_scoreboard;
        logic [6:0]  reg_width;
        logic [6:0]  reg_height;
        logic [7:0]  cell_flags[MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
        bit          cell_loaded[MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
        int          load_ptr;
        bit          seen[VERT_CAP];
        int          stack_vert[VERT_CAP];
        int          stack_cur[VERT_CAP];
        int          cut_list[VERT_CAP];
        int          cut_len;
        cut_answer_t awaited[$];
        int          mismatches;

        function new();
            reg_width = 7'd64;
            reg_height = 7'd64;
            load_ptr = 0;
            cut_len = 0;
            mismatches = 0;
            foreach (cell_loaded[i]) cell_loaded[i] = 0;
        endfunction

        function int clamp(logic [6:0] r, int hi);
            if (r == 0) return 1;
            if (r > hi) return hi;
            return r;
        endfunction

        function int cells();
            return clamp(reg_width, MAX_WIDTH_DEF) * clamp(reg_height, MAX_HEIGHT_DEF);
        endfunction

        function bit grid_loaded();
            int n;
            n = cells();
            for (int i = 0; i < n; i++) if (!cell_loaded[i]) return 0;
            return 1;
        endfunction

        function void mark(int v, int n, ref int sp);
            seen[v] = 1;
            cut_list[cut_len] = v;
            cut_len++;
            stack_vert[sp] = v;
            stack_cur[sp] = (v == 0 || v == n + 1) ? n : 0;
            sp++;
        endfunction

        function void walk_from_sink();
            int w, h, n, sp, v, nb, idx, c, row, col, slot;
            logic [7:0] f, pick;
            bit found;
            w = clamp(reg_width, MAX_WIDTH_DEF);
            h = clamp(reg_height, MAX_HEIGHT_DEF);
            n = w * h;
            foreach (seen[i]) seen[i] = 0;
            cut_len = 0;
            sp = 0;
            mark(n + 1, n, sp);
            while (sp > 0) begin
                v = stack_vert[sp-1];
                found = 0;
                nb = 0;
                if (v == 0 || v == n + 1) begin
                    pick = (v == 0) ? F_FROM_SRC : F_FROM_SINK;
                    while (stack_cur[sp-1] >= 1 && !found) begin
                        idx = stack_cur[sp-1];
                        stack_cur[sp-1] = idx - 1;
                        if ((cell_flags[idx-1] & pick) != 0) begin
                            nb = idx;
                            found = 1;
                        end
                    end
                end else begin
                    c = v - 1;
                    row = c / w;
                    col = c % w;
                    f = cell_flags[c];
                    while (stack_cur[sp-1] < 6 && !found) begin
                        slot = stack_cur[sp-1];
                        stack_cur[sp-1] = slot + 1;
                        case (slot)
                            0: if ((f & F_UP) != 0 && row > 0) begin
                                nb = v - w; found = 1;
                            end
                            1: if ((f & F_LEFT) != 0 && col > 0) begin
                                nb = v - 1; found = 1;
                            end
                            2: if ((f & F_DOWN) != 0 && row + 1 < h) begin
                                nb = v + w; found = 1;
                            end
                            3: if ((f & F_RIGHT) != 0 && col + 1 < w) begin
                                nb = v + 1; found = 1;
                            end
                            4: if ((f & F_TO_SINK) != 0) begin
                                nb = n + 1; found = 1;
                            end
                            default: if ((f & F_TO_SRC) != 0) begin
                                nb = 0; found = 1;
                            end
                        endcase
                    end
                end
                if (!found) sp--;
                else if (!seen[nb]) mark(nb, n, sp);
            end
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] flags, logic [12:0] pos);
            cut_answer_t a;
            int n, p;
            a.vertex = 0;
            a.valid = 0;
            if (cmd == CMD_LOAD) begin
                n = cells();
                p = (load_ptr < n) ? load_ptr : 0;
                cell_flags[p] = flags;
                cell_loaded[p] = 1;
                p++;
                load_ptr = (p >= n) ? 0 : p;
            end else if (cmd == CMD_WALK) begin
                walk_from_sink();
            end else if (cmd == CMD_READ && pos < cut_len) begin
                a.vertex = 13'(cut_list[pos]);
                a.valid = 1;
            end
            a.count = 13'(cut_len);
            awaited.insert(awaited.size(), a);
        endfunction

        function void check_answer(logic [31:0] data, logic user);
            cut_answer_t e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", data, user);
                return;
            end
            e = awaited.pop_front();
            if (data[12:0] !== e.vertex || data[25:13] !== e.count || user !== e.valid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected vertex %0d count %0d valid %0d, got %0d %0d %0d",
                             e.vertex, e.count, e.valid, data[12:0], data[25:13], user);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;   // cell_flags[7:0], position[20:8]
    logic [1:0]  s_tuser = 0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;       // cut_vertex[12:0], cut_count[25:13]
    logic        m_tuser;       // entry_valid

    cut_scoreboard sb = new();
    int send_idle = 28;
    int recv_idle = 46;
    int recv_hold = 0;

    grid_residual_cut_walk dut (.*);

    always #2 aclk = ~aclk;

    initial begin
        forever begin
            @(negedge aclk);
            if (recv_hold > 0) begin
                m_tready = 0;
                recv_hold--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_idle);
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_answer(m_tdata, m_tuser);
        end
    end

    task automatic send(logic [1:0] cmd, logic [7:0] flags, logic [12:0] pos);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {3'b000, pos, flags};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, flags, pos);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (sb.awaited.size() != 0) @(negedge aclk);
    endtask

    task automatic apb_write(int idx, logic [6:0] val);
        drain();
        psel = 1; pwrite = 1; penable = 0;
        paddr = 3'(idx * 4);
        pwdata = {25'd0, val};
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        if (idx == REG_WIDTH) sb.reg_width = val;
        else sb.reg_height = val;
    endtask

    function automatic logic [7:0] rand_flags();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 255) | $urandom_range(0, 255)) | F_FROM_SINK;
    endfunction

    task automatic run_phase(logic [6:0] w, logic [6:0] h, int count);
        int r;
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        repeat (sb.cells()) send(CMD_LOAD, rand_flags(), 13'($urandom_range(0, 8191)));
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15 && sb.grid_loaded())
                send(CMD_WALK, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
            else if (r < 60)
                send(CMD_READ, 8'($urandom_range(0, 255)), 13'($urandom_range(0, sb.cut_len)));
            else if (r < 80)
                send(CMD_LOAD, rand_flags(), 13'($urandom_range(0, 8191)));
            else if (r < 92)
                send(CMD_READ, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
            else
                send(CMD_SPARE, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // corner grid with full and empty cells
        apb_write(REG_WIDTH, 7'd3);
        apb_write(REG_HEIGHT, 7'd2);
        send(CMD_READ, 8'h00, 13'd0);
        send(CMD_LOAD, 8'hFF, 13'd0);
        send(CMD_LOAD, 8'h00, 13'h1FFF);
        send(CMD_LOAD, 8'h5A, 13'd0);
        send(CMD_LOAD, 8'hA5, 13'd0);
        send(CMD_LOAD, 8'hFF, 13'd0);
        send(CMD_LOAD, 8'h0F, 13'd0);
        send(CMD_WALK, 8'h00, 13'd0);
        send(CMD_READ, 8'hFF, 13'd0);
        send(CMD_READ, 8'h00, 13'(sb.cut_len - 1));
        send(CMD_READ, 8'h00, 13'(sb.cut_len));
        send(CMD_READ, 8'h00, 13'h1FFF);
        send(CMD_SPARE, 8'hFF, 13'h1FFF);
        send(CMD_LOAD, 8'h04, 13'd0);
        send(CMD_WALK, 8'hFF, 13'h1FFF);
        send(CMD_READ, 8'h00, 13'd1);

        run_phase(7'd4, 7'd3, 20);
        run_phase(7'd64, 7'd1, 20);
        run_phase(7'd1, 7'd9, 15);
        send_idle = 46; recv_idle = 28;
        run_phase(7'd0, 7'd127, 15);
        run_phase(7'd127, 7'd0, 15);
        run_phase(7'd4, 7'd4, 15);
        recv_hold = 300;
        repeat (40) send(CMD_READ, 8'($urandom_range(0, 255)),
                         13'($urandom_range(0, sb.cut_len)));
        drain();
        run_phase(7'd8, 7'd2, 20);
        send_idle = 0; recv_idle = 0;
        run_phase(7'd2, 7'd2, 15);
        run_phase(7'd5, 7'd7, 25);

        drain();
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
